### src/irenc_pkg.sv
// ----------------------------------------------------------------------------
// irenc_pkg
// Shared types and constants for the interleaved Rice encoder.
// ----------------------------------------------------------------------------
package irenc_pkg;

   // Fixed field widths of the ports and internal registers
   localparam int IN_BITS    = 16;
   localparam int K_BITS     = 4;
   localparam int BYTE_BITS  = 8;
   localparam int PEND_BITS  = 7;
   localparam int PCNT_BITS  = 3;
   localparam int STEP_BITS  = 4;   // bits moved in one step, 0..8
   localparam int FIELD_BITS = 15;  // remainder bits, k is at most 15
   localparam int FREM_BITS  = 5;   // remainder bits plus stop bit, 1..16
   localparam int CSR_IDX_BITS = 1;

   // Register indexes of the write port
   localparam logic [CSR_IDX_BITS-1:0] REG_PARAM_FIRST  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PARAM_SECOND = 1'd1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUOT1,
      ST_QUOT2,
      ST_OVF,
      ST_CODE,
      ST_FLUSH
   } irenc_state_type;

endpackage

### src/interleaved_rice_encoder_unit.sv
// ----------------------------------------------------------------------------
// interleaved_rice_encoder_unit
// Rice-codes a pair of values with two parameters and packs the code bits
// MSB first into bytes, using one shared bit-packing step under a sequencer.
// ----------------------------------------------------------------------------
//
//  channel  ports   direction  beat
//  -------  ------  ---------  ------------------------------------------------
//  req      req_*   in         first_value, second_value, end_of_block
//  rsp      rsp_*   out        byte_out, last_of_run, block_done, overflow
//  csr      csr_*   in         write of param_first (0) or param_second (1)
//
//  A pair takes two quotient checks, then one packing step per cycle unless a
//  completed byte stalls; a step moves up to 8 bits, cut at a byte boundary or
//  a segment end (ones run, stop bit plus remainder), plus a flush step at the
//  end of a block. A rejected pair gives its overflow beat after the checks.
//  Reset clears the sequencer, the pending bits and both parameters.
//  A completed byte waits in the output register; the packer stalls only when
//  a second byte completes before the first is taken. req_ready is high in
//  idle alone.
// ----------------------------------------------------------------------------
module interleaved_rice_encoder_unit #(
   parameter int VALUE_BITS   = 16,
   parameter int MAX_QUOTIENT = 200
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [irenc_pkg::IN_BITS-1:0]       req_first_value,
   input  logic [irenc_pkg::IN_BITS-1:0]       req_second_value,
   input  logic                                req_end_of_block,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [irenc_pkg::BYTE_BITS-1:0]     rsp_byte_out,
   output logic                                rsp_last_of_run,
   output logic                                rsp_block_done,
   output logic                                rsp_overflow,
   // configuration write port
   input  logic                                csr_we,
   input  logic [irenc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [irenc_pkg::K_BITS-1:0]        csr_wdata
);
   import irenc_pkg::*;

   localparam int CODE_BITS = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
   localparam int QW        = (MAX_QUOTIENT < 2) ? 1 : $clog2(MAX_QUOTIENT + 1);
   localparam int TW        = $clog2(2 * MAX_QUOTIENT + 33);

   // Control registers
   irenc_state_type         state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PEND_BITS-1:0]    acc_ff, acc_in;
   logic [PCNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [K_BITS-1:0]       param_first_ff, param_first_in;
   logic [K_BITS-1:0]       param_second_ff, param_second_in;

   // Work registers
   logic [CODE_BITS-1:0]    val1_ff, val1_in;
   logic [CODE_BITS-1:0]    val2_ff, val2_in;
   logic                    eob_ff, eob_in;
   logic [QW-1:0]           q1_ff, q1_in;
   logic [QW-1:0]           q2_ff, q2_in;
   logic                    over_ff, over_in;
   logic                    sel_ff, sel_in;
   logic [QW-1:0]           qrem_ff, qrem_in;
   logic [FREM_BITS-1:0]    frem_ff, frem_in;
   logic [FIELD_BITS-1:0]   field_ff, field_in;
   logic [TW-1:0]           rem_ff, rem_in;

   // Output payload registers
   logic [BYTE_BITS-1:0]    byte_ff, byte_in;
   logic                    last_ff, last_in;
   logic                    done_ff, done_in;
   logic                    ovf_ff, ovf_in;

   // Shared quotient shifter
   logic [CODE_BITS-1:0]    sh_val;
   logic [K_BITS-1:0]       sh_k;
   logic [CODE_BITS-1:0]    sh_q;
   logic                    sh_over;

   // Shared packing step
   logic                    out_free;
   logic                    out_load;
   logic [STEP_BITS-1:0]    space;
   logic                    run;
   logic [STEP_BITS-1:0]    n;
   logic [FREM_BITS-1:0]    fsh;
   logic [BYTE_BITS-1:0]    bits8;
   logic [BYTE_BITS-1:0]    merged;
   logic [STEP_BITS-1:0]    cnt_sum;
   logic                    full;
   logic [TW-1:0]           rem_next;
   logic                    is_last;
   logic [FREM_BITS-1:0]    frem_next;
   logic [IN_BITS-1:0]      val2_wide;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_out    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_block_done  = done_ff;
   assign rsp_overflow    = ovf_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Quotient of the value picked by the sequencer
   always_comb begin
      sh_val  = (state_ff == ST_QUOT2) ? val2_ff : val1_ff;
      sh_k    = (state_ff == ST_QUOT2) ? param_second_ff : param_first_ff;
      sh_q    = sh_val >> sh_k;
      sh_over = (32'(sh_q) > 32'(MAX_QUOTIENT));
   end

   // Bits of one packing step: a slice of the ones run or of the field
   always_comb begin
      space = STEP_BITS'(BYTE_BITS) - {1'b0, cnt_ff};
      run   = (qrem_ff != '0);
      fsh   = '0;
      if (run) begin
         n     = (32'(qrem_ff) < 32'(space)) ? STEP_BITS'(qrem_ff) : space;
         bits8 = 8'hFF >> (STEP_BITS'(BYTE_BITS) - n);
      end else begin
         n     = (32'(frem_ff) < 32'(space)) ? STEP_BITS'(frem_ff) : space;
         fsh   = frem_ff - FREM_BITS'(n);
         bits8 = BYTE_BITS'({1'b0, field_ff} >> fsh)
                 & (8'hFF >> (STEP_BITS'(BYTE_BITS) - n));
      end
      merged    = (BYTE_BITS'({1'b0, acc_ff}) << n) | bits8;
      cnt_sum   = {1'b0, cnt_ff} + n;
      full      = (cnt_sum == STEP_BITS'(BYTE_BITS));
      rem_next  = rem_ff - TW'(n);
      is_last   = (rem_next == '0) || (!eob_ff && (rem_next < TW'(BYTE_BITS)));
      frem_next = frem_ff - FREM_BITS'(n);
      val2_wide = IN_BITS'(val2_ff) & ~(16'hFFFF << param_second_ff);
   end

   // Sequencer: next state, work registers and output register loads
   always_comb begin
      state_in        = state_ff;
      acc_in          = acc_ff;
      cnt_in          = cnt_ff;
      param_first_in  = param_first_ff;
      param_second_in = param_second_ff;
      val1_in         = val1_ff;
      val2_in         = val2_ff;
      eob_in          = eob_ff;
      q1_in           = q1_ff;
      q2_in           = q2_ff;
      over_in         = over_ff;
      sel_in          = sel_ff;
      qrem_in         = qrem_ff;
      frem_in         = frem_ff;
      field_in        = field_ff;
      rem_in          = rem_ff;
      byte_in         = byte_ff;
      last_in         = last_ff;
      done_in         = done_ff;
      ovf_in          = ovf_ff;
      out_load        = 1'b0;

      // take register writes
      if (csr_we) begin
         case (csr_index)
            REG_PARAM_FIRST:  param_first_in  = csr_wdata;
            REG_PARAM_SECOND: param_second_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val1_in  = CODE_BITS'(req_first_value);
               val2_in  = CODE_BITS'(req_second_value);
               eob_in   = req_end_of_block;
               state_in = ST_QUOT1;
            end
         end
         ST_QUOT1: begin
            q1_in    = QW'(sh_q);
            over_in  = sh_over;
            state_in = ST_QUOT2;
         end
         ST_QUOT2: begin
            q2_in = QW'(sh_q);
            if (over_ff || sh_over) begin
               state_in = ST_OVF;
            end else begin
               // total code bits of the pair, and load the first segment
               rem_in   = TW'(q1_ff) + TW'(sh_q) + TW'(param_first_ff)
                          + TW'(param_second_ff) + TW'(2);
               sel_in   = 1'b0;
               qrem_in  = q1_ff;
               frem_in  = FREM_BITS'(param_first_ff) + FREM_BITS'(1);
               field_in = FIELD_BITS'(IN_BITS'(val1_ff)
                                      & ~(16'hFFFF << param_first_ff));
               state_in = ST_CODE;
            end
         end
         ST_OVF: begin
            // reject the pair with a single beat, pending bits untouched
            if (out_free) begin
               out_load = 1'b1;
               byte_in  = '0;
               last_in  = 1'b1;
               done_in  = 1'b0;
               ovf_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CODE: begin
            // advance unless a completed byte finds the output still full
            if (!full || out_free) begin
               rem_in = rem_next;
               if (full) begin
                  out_load = 1'b1;
                  byte_in  = merged;
                  last_in  = is_last;
                  done_in  = is_last && eob_ff;
                  ovf_in   = 1'b0;
                  acc_in   = '0;
                  cnt_in   = '0;
               end else begin
                  acc_in = PEND_BITS'(merged);
                  cnt_in = PCNT_BITS'(cnt_sum);
               end
               if (run) begin
                  qrem_in = qrem_ff - QW'(n);
               end else begin
                  frem_in = frem_next;
                  if (frem_next == '0) begin
                     if (!sel_ff) begin
                        sel_in   = 1'b1;
                        qrem_in  = q2_ff;
                        frem_in  = FREM_BITS'(param_second_ff) + FREM_BITS'(1);
                        field_in = FIELD_BITS'(val2_wide);
                     end else if (eob_ff && !full) begin
                        state_in = ST_FLUSH;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         ST_FLUSH: begin
            // pad the partial byte with zeros at the end of a block
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load = 1'b1;
               byte_in  = BYTE_BITS'({1'b0, acc_ff})
                          << (STEP_BITS'(BYTE_BITS) - {1'b0, cnt_ff});
               last_in  = 1'b1;
               done_in  = 1'b1;
               ovf_in   = 1'b0;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold or drop the output beat
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         acc_ff          <= '0;
         cnt_ff          <= '0;
         param_first_ff  <= '0;
         param_second_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         acc_ff          <= acc_in;
         cnt_ff          <= cnt_in;
         param_first_ff  <= param_first_in;
         param_second_ff <= param_second_in;
      end
   end

   // Work and payload registers
   always_ff @(posedge clock) begin
      val1_ff  <= val1_in;
      val2_ff  <= val2_in;
      eob_ff   <= eob_in;
      q1_ff    <= q1_in;
      q2_ff    <= q2_in;
      over_ff  <= over_in;
      sel_ff   <= sel_in;
      qrem_ff  <= qrem_in;
      frem_ff  <= frem_in;
      field_ff <= field_in;
      rem_ff   <= rem_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
      ovf_ff   <= ovf_in;
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interleaved_rice_encoder_unit: drives pairs of
// values under random gaps and stalls, predicts the packed Rice code bytes
// and checks every response beat in order against the prediction.
// ----------------------------------------------------------------------------
module tb;
   import irenc_pkg::*;

   localparam int VALUE_BITS    = 16;
   localparam int MAX_QUOTIENT  = 200;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_ITEMS   = 50;
   localparam int PHASE_COUNT   = 8;
   localparam int PRINT_LIMIT   = 50;

   // One response beat as seen on the rsp_ ports
   typedef struct packed {
      logic [BYTE_BITS-1:0] code_byte;
      logic                 last_of_run;
      logic                 block_done;
      logic                 overflow;
   } code_beat_type;

   // Tracks the encoder state and the bytes still owed by the block
   class rice_byte_board;
      code_beat_type        expected_q[$];
      code_beat_type        run_q[$];
      logic [K_BITS-1:0]    k_first;
      logic [K_BITS-1:0]    k_second;
      logic [PEND_BITS-1:0] pend_bits;
      logic [PCNT_BITS-1:0] pend_cnt;
      logic [7:0]           work_acc;
      int                   work_cnt;
      int                   errors;

      function new();
         k_first   = '0;
         k_second  = '0;
         pend_bits = '0;
         pend_cnt  = '0;
         errors    = 0;
      endfunction

      // Append a beat to the bytes of the current pair
      function void queue_run(code_beat_type b);
         run_q.insert(run_q.size(), b);
      endfunction

      // Append a beat to the bytes owed by the block
      function void queue_expected(code_beat_type b);
         expected_q.insert(expected_q.size(), b);
      endfunction

      function void set_param(logic [CSR_IDX_BITS-1:0] idx, logic [K_BITS-1:0] val);
         if (idx == REG_PARAM_FIRST) begin
            k_first = val;
         end else if (idx == REG_PARAM_SECOND) begin
            k_second = val;
         end
      endfunction

      // Shift one code bit in; emit a byte when eight have gathered
      function void add_bit(logic b);
         work_acc = {work_acc[6:0], b};
         work_cnt++;
         if (work_cnt == 8) begin
            queue_run('{code_byte: work_acc, last_of_run: 1'b0,
                        block_done: 1'b0, overflow: 1'b0});
            work_acc = '0;
            work_cnt = 0;
         end
      endfunction

      // Unary quotient, stop bit, then k remainder bits MSB first
      function void code_value(int unsigned v, int k);
         int unsigned q;
         q = v >> k;
         for (int unsigned i = 0; i < q; i++) add_bit(1'b1);
         add_bit(1'b0);
         for (int i = k; i > 0; i--) add_bit(v[i-1]);
      endfunction

      function void note_pair(logic [IN_BITS-1:0] first_value,
                              logic [IN_BITS-1:0] second_value, logic eob);
         int unsigned   v1;
         int unsigned   v2;
         logic [7:0]    padded;
         code_beat_type tail;
         v1 = 32'(first_value)  & 32'((64'd1 << VALUE_BITS) - 1);
         v2 = 32'(second_value) & 32'((64'd1 << VALUE_BITS) - 1);
         // Reject the whole pair on an oversized quotient, state untouched
         if ((v1 >> k_first) > MAX_QUOTIENT || (v2 >> k_second) > MAX_QUOTIENT) begin
            queue_expected('{code_byte: '0, last_of_run: 1'b1,
                             block_done: 1'b0, overflow: 1'b1});
            return;
         end
         run_q.delete();
         work_acc = {1'b0, pend_bits};
         work_cnt = int'(pend_cnt);
         code_value(v1, int'(k_first));
         code_value(v2, int'(k_second));
         // Flush a partial byte on the last pair, padded with zeros
         if (eob && work_cnt > 0) begin
            padded = work_acc << (8 - work_cnt);
            queue_run('{code_byte: padded, last_of_run: 1'b0,
                        block_done: 1'b0, overflow: 1'b0});
            work_acc = '0;
            work_cnt = 0;
         end
         pend_bits = work_acc[PEND_BITS-1:0];
         pend_cnt  = PCNT_BITS'(work_cnt);
         // Mark the final beat of this pair
         if (run_q.size() > 0) begin
            tail = run_q.pop_back();
            tail.last_of_run = 1'b1;
            tail.block_done  = eob;
            queue_run(tail);
         end
         foreach (run_q[i]) queue_expected(run_q[i]);
      endfunction

      task report(string msg);
         if (errors < PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_byte(code_beat_type got);
         code_beat_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected beat byte=%02h", got.code_byte));
            return;
         end
         want = expected_q.pop_front();
         if (got.code_byte !== want.code_byte)
            report($sformatf("byte_out %02h, want %02h", got.code_byte, want.code_byte));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
         if (got.block_done !== want.block_done)
            report($sformatf("block_done %b, want %b", got.block_done, want.block_done));
         if (got.overflow !== want.overflow)
            report($sformatf("overflow %b, want %b", got.overflow, want.overflow));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [IN_BITS-1:0]      req_first_value;
   logic [IN_BITS-1:0]      req_second_value;
   logic                    req_end_of_block;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [BYTE_BITS-1:0]    rsp_byte_out;
   logic                    rsp_last_of_run;
   logic                    rsp_block_done;
   logic                    rsp_overflow;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [K_BITS-1:0]       csr_wdata;

   rice_byte_board board;
   bit             idling_on;

   interleaved_rice_encoder_unit #(
      .VALUE_BITS   (VALUE_BITS),
      .MAX_QUOTIENT (MAX_QUOTIENT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .req_end_of_block (req_end_of_block),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_block_done   (rsp_block_done),
      .rsp_overflow     (rsp_overflow),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // Note accepted pairs and check accepted bytes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_pair(req_first_value, req_second_value, req_end_of_block);
         if (rsp_valid && rsp_ready)
            board.check_byte('{rsp_byte_out, rsp_last_of_run, rsp_block_done, rsp_overflow});
      end
   end

   // Stall the response side for a random number of cycles per beat
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = idling_on ? $urandom_range(0, 19) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offer one pair after a random gap; hold it until accepted
   task send_pair(logic [IN_BITS-1:0] first_value, logic [IN_BITS-1:0] second_value,
                  logic eob);
      int gap;
      gap = idling_on ? $urandom_range(0, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_first_value  <= first_value;
      req_second_value <= second_value;
      req_end_of_block <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid, wait for every owed byte, then let the block settle
   task wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_param(logic [CSR_IDX_BITS-1:0] idx, logic [K_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_param(idx, val);
   endtask

   task set_params(logic [K_BITS-1:0] kf, logic [K_BITS-1:0] ks);
      write_param(REG_PARAM_FIRST, kf);
      write_param(REG_PARAM_SECOND, ks);
   endtask

   // Mostly small quotients, some near the bound, some raw noise
   function automatic logic [IN_BITS-1:0] pick_value(logic [K_BITS-1:0] k);
      int          sel;
      int unsigned q;
      int unsigned qmax;
      logic [31:0] v;
      sel  = $urandom_range(0, 99);
      qmax = 65535 >> k;
      if (sel < 10) begin
         v = $urandom;
      end else begin
         q = (sel < 16) ? $urandom_range(150, 205) : $urandom_range(0, 6);
         if (q > qmax) q = qmax;
         v = (q << k) | ($urandom & ((32'd1 << k) - 1));
      end
      return v[IN_BITS-1:0];
   endfunction

   initial begin
      logic [K_BITS-1:0] kf;
      logic [K_BITS-1:0] ks;
      board            = new();
      clock            = 1'b0;
      reset            = 1'b1;
      idling_on        = 1'b1;
      req_valid        = 1'b0;
      req_first_value  = '0;
      req_second_value = '0;
      req_end_of_block = 1'b0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: both parameters at their reset value of zero
      send_pair(16'd0, 16'd0, 1'b0);          // no byte completes
      send_pair(16'd3, 16'd2, 1'b0);
      send_pair(16'd200, 16'd0, 1'b0);        // quotient right at the bound
      send_pair(16'd201, 16'd0, 1'b0);        // quotient over the bound
      send_pair(16'd0, 16'd201, 1'b1);        // rejected last pair, no flush
      send_pair(16'hFFFF, 16'hFFFF, 1'b0);
      send_pair(16'd5, 16'd1, 1'b1);          // flush with padding
      send_pair(16'd3, 16'd3, 1'b1);          // ends on a byte boundary
      send_pair(16'd0, 16'd0, 1'b1);
      wait_drain();

      // Directed: widest remainders
      set_params(4'd15, 4'd15);
      send_pair(16'hFFFF, 16'hFFFF, 1'b1);
      send_pair(16'd0, 16'd0, 1'b0);
      send_pair(16'h7FFF, 16'h8000, 1'b1);
      wait_drain();

      // Directed: mixed extremes
      set_params(4'd0, 4'd15);
      send_pair(16'd200, 16'hFFFF, 1'b1);
      send_pair(16'd1, 16'd0, 1'b0);
      send_pair(16'd0, 16'd201, 1'b1);
      wait_drain();
      set_params(4'd15, 4'd0);
      send_pair(16'hFFFF, 16'd200, 1'b1);
      send_pair(16'hFFFF, 16'd201, 1'b0);
      send_pair(16'd0, 16'd0, 1'b1);
      wait_drain();

      // Random phases, one parameter setting each
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin kf = 4'd0;  ks = 4'd0;  end
            1: begin kf = 4'd15; ks = 4'd15; end
            2: begin kf = 4'd0;  ks = 4'd15; end
            3: begin kf = 4'd15; ks = 4'd0;  end
            default: begin
               kf = K_BITS'($urandom_range(0, 15));
               ks = K_BITS'($urandom_range(0, 15));
            end
         endcase
         set_params(kf, ks);
         idling_on = (phase % 4) != 3;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Hold off once until the block has caught up
            if (phase == 1 && n == PHASE_ITEMS / 2) begin
               @(negedge clock);
               req_valid <= 1'b0;
               while (board.expected_q.size() != 0) @(posedge clock);
            end
            send_pair(pick_value(kf), pick_value(ks), $urandom_range(0, 7) == 0);
         end
         wait_drain();
      end

      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #30000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
